[hdl/tce_pkg.sv]
// shared types and constants of the text console engine
package tce_pkg;

  typedef enum logic [2:0] {
    REQ_PUT    = 3'd0,
    REQ_HOOK   = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_SET    = 3'd3,
    REQ_ENABLE = 3'd4,
    REQ_TICK   = 3'd5,
    REQ_READ   = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef struct packed {
    req_t       req;
    logic [7:0] ch7;
    logic       is_nl;
    logic       is_bs;
    logic       prn;
    logic       hook_clr;
    logic       hook_wr;
    logic [7:0] tcol;
    logic [7:0] trow;
    logic [7:0] pcol;
    logic [7:0] prow;
  } req_item_t;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] PLAIN_ATTR = 8'h61;
  localparam logic [7:0] CH_EOL     = 8'h9B;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_DEL     = 8'h7E;
  localparam logic [7:0] CH_CLR     = 8'h7D;
  localparam logic [7:0] CH_MASK    = 8'h7F;
  localparam logic [7:0] COLOR_HI   = 8'hF0;
  localparam logic [7:0] COLOR_LO   = 8'h0F;

endpackage

[hdl/tce_ram.sv]
// generic single write port, single read port ram with registered read
module tce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/tce_front.sv]
// request intake: classification and a two entry request queue
module tce_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic [7:0]         in_char_code,
  input  logic [7:0]         in_target_col,
  input  logic [7:0]         in_target_row,
  input  logic [7:0]         in_prev_col,
  input  logic [7:0]         in_prev_row,
  input  logic               init_busy,
  output logic               q_valid,
  output tce_pkg::req_item_t q_item,
  input  logic               q_pop
);
  import tce_pkg::*;

  localparam logic [7:0] COL_LIM = 8'(COLUMNS);
  localparam logic [7:0] ROW_LIM = 8'(ROWS);
  localparam logic [7:0] COL_MAX = 8'(COLUMNS - 1);
  localparam logic [7:0] ROW_MAX = 8'(ROWS - 1);

  req_item_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_item_t  item;
  logic       push;
  logic [7:0] ch7;
  logic       nl;

  assign ch7  = in_char_code & CH_MASK;
  assign nl   = (in_char_code == CH_EOL) || (in_char_code == CH_ESC) ||
                (in_char_code == CH_LF) || (in_char_code == CH_CR);

  always_comb begin
    item          = '0;
    item.req      = req_t'(in_req_type);
    item.ch7      = ch7;
    item.is_nl    = nl;
    item.is_bs    = (ch7 == CH_BS) || (ch7 == CH_DEL);
    item.prn      = ch7 >= BLANK_CHAR;
    item.hook_clr = in_char_code == CH_CLR;
    item.hook_wr  = !nl && (ch7 >= BLANK_CHAR) && (in_prev_col < COL_LIM) &&
                    (in_prev_row < ROW_LIM);
    item.tcol     = (in_target_col >= COL_LIM) ? COL_MAX : in_target_col;
    item.trow     = (in_target_row >= ROW_LIM) ? ROW_MAX : in_target_row;
    item.pcol     = in_prev_col;
    item.prow     = in_prev_row;
  end

  assign busy    = (cnt_r == 2'd2) || init_busy;
  assign push    = start && !busy;
  assign q_valid = cnt_r != 2'd0;
  assign q_item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

[hdl/tce_back.sv]
// request execution: cursor, blink, metronome and screen store sequencer
module tce_back #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int BLINK_FRAMES = 20,
  parameter int CLICK_FRAMES = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       q_valid,
  input  tce_pkg::req_item_t         q_item,
  output logic                       q_pop,
  output logic                       init_busy,
  output logic                       out_valid,
  output logic [$clog2(COLUMNS)-1:0] out_cursor_col,
  output logic [$clog2(ROWS)-1:0]    out_cursor_row,
  output logic [7:0]                 out_cell_char,
  output logic [7:0]                 out_cell_color,
  output logic                       out_click_on,
  output logic                       out_cursor_visible
);
  import tce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int BW    = $clog2(BLINK_FRAMES + 1);
  localparam int KW    = $clog2(CLICK_FRAMES + 1);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW0  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_MAX    = RW'(ROWS - 1);
  localparam logic [BW-1:0] BLINK_INIT = BW'(BLINK_FRAMES);
  localparam logic [KW-1:0] CLICK_INIT = KW'(CLICK_FRAMES);

  typedef enum logic [15:0] {
    S_INIT   = 16'h0001,
    S_IDLE   = 16'h0002,
    S_HIDE   = 16'h0004,
    S_PUTC   = 16'h0008,
    S_HOOKW  = 16'h0010,
    S_SET    = 16'h0020,
    S_NEWL   = 16'h0040,
    S_SCR_RD = 16'h0080,
    S_SCR_WR = 16'h0100,
    S_FILL   = 16'h0200,
    S_TCH_RD = 16'h0400,
    S_TCH_WR = 16'h0800,
    S_TICK   = 16'h1000,
    S_RD     = 16'h2000,
    S_RD2    = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  typedef enum logic [2:0] {
    OP_PUT, OP_HOOKW, OP_CLEAR, OP_SET, OP_EN
  } op_t;

  function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] c, logic [RW-1:0] r);
    return AW'(r) * ROW_STRIDE + AW'(c);
  endfunction

  state_t     st_r, st_nxt;
  op_t        op_r, op_nxt;
  logic       pend_r, pend_nxt;
  req_item_t  item_r, item_nxt;
  logic [CW-1:0] col_r, col_nxt, dcol_r, dcol_nxt;
  logic [RW-1:0] row_r, row_nxt, drow_r, drow_nxt;
  logic [15:0] saved_r, saved_nxt;
  logic       drawn_r, drawn_nxt, en_r, en_nxt, phase_r, phase_nxt;
  logic [BW-1:0] blink_r, blink_nxt;
  logic [KW-1:0] clickc_r, clickc_nxt;
  logic       click_r, click_nxt, met_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [15:0] rd_r, rd_nxt;
  logic       ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [CW:0]   col_inc;
  logic [7:0]    scol;

  tce_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign scol      = saved_r[7:0];
  assign init_busy = st_r == S_INIT;

  always_comb begin
    st_nxt    = st_r;
    op_nxt    = op_r;
    pend_nxt  = pend_r;
    item_nxt  = item_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    dcol_nxt  = dcol_r;
    drow_nxt  = drow_r;
    saved_nxt = saved_r;
    drawn_nxt = drawn_r;
    en_nxt    = en_r;
    phase_nxt = phase_r;
    blink_nxt = blink_r;
    clickc_nxt = clickc_r;
    click_nxt = click_r;
    idx_nxt   = idx_r;
    rd_nxt    = rd_r;
    ov_nxt    = 1'b0;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = {BLANK_CHAR, PLAIN_ATTR};
    raddr     = idx_r;
    unique case (st_r)
      S_INIT: begin
        we = 1'b1;
        if (idx_r == LAST_CELL) begin
          st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          rd_nxt   = '0;
          st_nxt   = S_HIDE;
          unique case (q_item.req)
            REQ_PUT: op_nxt = OP_PUT;
            REQ_HOOK: begin
              if (q_item.hook_clr) begin
                op_nxt   = OP_CLEAR;
                pend_nxt = 1'b1;
              end else if (q_item.hook_wr) begin
                op_nxt = OP_HOOKW;
              end else begin
                op_nxt = OP_SET;
              end
            end
            REQ_CLEAR:  op_nxt = OP_CLEAR;
            REQ_SET:    op_nxt = OP_SET;
            REQ_ENABLE: op_nxt = OP_EN;
            REQ_TICK:   st_nxt = S_TICK;
            REQ_READ:   st_nxt = S_RD;
            default:    st_nxt = S_DONE;
          endcase
        end
      end
      S_HIDE: begin
        if (drawn_r) begin
          we        = 1'b1;
          waddr     = cell_addr(dcol_r, drow_r);
          wdata     = saved_r;
          drawn_nxt = 1'b0;
        end
        unique case (op_r)
          OP_PUT:   st_nxt = S_PUTC;
          OP_HOOKW: st_nxt = S_HOOKW;
          OP_CLEAR: begin
            idx_nxt = '0;
            col_nxt = '0;
            row_nxt = '0;
            st_nxt  = S_FILL;
          end
          OP_SET:   st_nxt = S_SET;
          OP_EN: begin
            en_nxt = 1'b1;
            st_nxt = S_TCH_RD;
          end
          default:  st_nxt = S_TCH_RD;
        endcase
      end
      S_PUTC: begin
        st_nxt = S_TCH_RD;
        if (item_r.is_nl) begin
          st_nxt = S_NEWL;
        end else if (item_r.is_bs) begin
          if (col_r != '0) begin
            we      = 1'b1;
            waddr   = cell_addr(col_r - 1'b1, row_r);
            col_nxt = col_r - 1'b1;
          end
        end else if (item_r.prn) begin
          we      = 1'b1;
          waddr   = cell_addr(col_r, row_r);
          wdata   = {item_r.ch7, PLAIN_ATTR};
          col_nxt = col_inc[CW-1:0];
          if (col_inc >= (CW + 1)'(COLUMNS)) begin
            st_nxt = S_NEWL;
          end
        end
      end
      S_HOOKW: begin
        we     = 1'b1;
        waddr  = cell_addr(item_r.pcol[CW-1:0], item_r.prow[RW-1:0]);
        wdata  = {item_r.ch7, PLAIN_ATTR};
        st_nxt = S_SET;
      end
      S_SET: begin
        col_nxt = item_r.tcol[CW-1:0];
        row_nxt = item_r.trow[RW-1:0];
        st_nxt  = S_TCH_RD;
      end
      S_NEWL: begin
        col_nxt = '0;
        if (row_r >= ROW_MAX) begin
          idx_nxt = '0;
          st_nxt  = S_SCR_RD;
        end else begin
          row_nxt = row_r + 1'b1;
          st_nxt  = S_TCH_RD;
        end
      end
      S_SCR_RD: begin
        raddr  = idx_r + ROW_STRIDE;
        st_nxt = S_SCR_WR;
      end
      S_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata;
        if (idx_r == LAST_COPY) begin
          idx_nxt = LAST_ROW0;
          st_nxt  = S_FILL;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt  = S_SCR_RD;
        end
      end
      S_FILL: begin
        we = 1'b1;
        if (idx_r == LAST_CELL) begin
          st_nxt = S_TCH_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TCH_RD: begin
        raddr = cell_addr(col_r, row_r);
        if (en_r) begin
          st_nxt = S_TCH_WR;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
          op_nxt   = OP_SET;
          st_nxt   = S_HIDE;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_TCH_WR: begin
        saved_nxt = rdata;
        we        = 1'b1;
        waddr     = cell_addr(col_r, row_r);
        wdata     = {BLANK_CHAR, rdata[7:4], rdata[7:4]};
        dcol_nxt  = col_r;
        drow_nxt  = row_r;
        drawn_nxt = 1'b1;
        phase_nxt = 1'b0;
        blink_nxt = BLINK_INIT;
        if (pend_r) begin
          pend_nxt = 1'b0;
          op_nxt   = OP_SET;
          st_nxt   = S_HIDE;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_TICK: begin
        click_nxt = 1'b0;
        if (!met_r) begin
          clickc_nxt = CLICK_INIT;
        end else if (clickc_r == KW'(1)) begin
          clickc_nxt = CLICK_INIT;
          click_nxt  = 1'b1;
        end else begin
          clickc_nxt = clickc_r - 1'b1;
        end
        if (blink_r != '0) begin
          blink_nxt = blink_r - 1'b1;
        end else begin
          blink_nxt = BLINK_INIT;
          if (drawn_r) begin
            phase_nxt = ~phase_r;
            we        = 1'b1;
            waddr     = cell_addr(dcol_r, drow_r);
            if (phase_r) begin
              wdata = {BLANK_CHAR, (scol & COLOR_HI) | ((scol & COLOR_HI) >> 4)};
            end else begin
              wdata = {BLANK_CHAR, ((scol & COLOR_LO) << 4) | (scol & COLOR_LO)};
            end
          end
        end
        st_nxt = S_DONE;
      end
      S_RD: begin
        raddr  = cell_addr(item_r.tcol[CW-1:0], item_r.trow[RW-1:0]);
        st_nxt = S_RD2;
      end
      S_RD2: begin
        rd_nxt = rdata;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_INIT;
      op_r     <= OP_SET;
      pend_r   <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      dcol_r   <= '0;
      drow_r   <= '0;
      saved_r  <= {BLANK_CHAR, PLAIN_ATTR};
      drawn_r  <= 1'b0;
      en_r     <= 1'b0;
      phase_r  <= 1'b0;
      blink_r  <= BLINK_INIT;
      clickc_r <= CLICK_INIT;
      click_r  <= 1'b0;
      met_r    <= 1'b0;
      idx_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      op_r     <= op_nxt;
      pend_r   <= pend_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      dcol_r   <= dcol_nxt;
      drow_r   <= drow_nxt;
      saved_r  <= saved_nxt;
      drawn_r  <= drawn_nxt;
      en_r     <= en_nxt;
      phase_r  <= phase_nxt;
      blink_r  <= blink_nxt;
      clickc_r <= clickc_nxt;
      click_r  <= click_nxt;
      idx_r    <= idx_nxt;
      ov_r     <= ov_nxt;
      if (cfg_wr_en) begin
        met_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rd_r   <= rd_nxt;
    if (ov_nxt) begin
      out_cursor_col     <= col_r;
      out_cursor_row     <= row_r;
      out_cell_char      <= rd_r[15:8];
      out_cell_color     <= rd_r[7:0];
      out_click_on       <= click_r;
      out_cursor_visible <= drawn_r;
    end
  end

  assign out_valid = ov_r;
endmodule

[hdl/text_console_engine.sv]
// text console engine top level: request queue, executor and screen store
// the executor takes each request from the queue; clear and a scroll on the last row pass over
// every cell of the screen store through one ram port pair
// two more requests may queue while the executor works on one
// reset: synchronous; then a fill pass blanks the screen with busy
// high; results are strobed one cycle and cannot be stalled
module text_console_engine #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int BLINK_FRAMES = 20,
  parameter int CLICK_FRAMES = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_req_type,
  input  logic [7:0]                 in_char_code,
  input  logic [7:0]                 in_target_col,
  input  logic [7:0]                 in_target_row,
  input  logic [7:0]                 in_prev_col,
  input  logic [7:0]                 in_prev_row,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  output logic                       out_valid,
  output logic [$clog2(COLUMNS)-1:0] out_cursor_col,
  output logic [$clog2(ROWS)-1:0]    out_cursor_row,
  output logic [7:0]                 out_cell_char,
  output logic [7:0]                 out_cell_color,
  output logic                       out_click_on,
  output logic                       out_cursor_visible
);
  import tce_pkg::*;

  logic      q_valid, q_pop, init_busy;
  req_item_t q_item;

  tce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_char_code(in_char_code),
    .in_target_col(in_target_col), .in_target_row(in_target_row),
    .in_prev_col(in_prev_col), .in_prev_row(in_prev_row),
    .init_busy(init_busy), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  tce_back #(
    .COLUMNS(COLUMNS), .ROWS(ROWS),
    .BLINK_FRAMES(BLINK_FRAMES), .CLICK_FRAMES(CLICK_FRAMES)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .init_busy(init_busy),
    .out_valid(out_valid), .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row), .out_cell_char(out_cell_char),
    .out_cell_color(out_cell_color), .out_click_on(out_click_on),
    .out_cursor_visible(out_cursor_visible)
  );
endmodule

[bench/tb_top.sv]
// self-checking testbench for the text console engine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tce_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int BLINK_FRAMES = 20;
  localparam int CLICK_FRAMES = 10;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] ch;
    logic [7:0] tcol;
    logic [7:0] trow;
    logic [7:0] pcol;
    logic [7:0] prow;
  } console_req_t;

  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] cch;
    logic [7:0] ccolor;
    logic       click;
    logic       vis;
  } console_status_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_req_type = '0;
  logic [7:0] in_char_code = '0, in_target_col = '0, in_target_row = '0;
  logic [7:0] in_prev_col = '0, in_prev_row = '0;
  logic cfg_wr_en = 0, cfg_wr_data = 0;
  logic out_valid;
  logic [6:0] out_cursor_col;
  logic [4:0] out_cursor_row;
  logic [7:0] out_cell_char, out_cell_color;
  logic out_click_on, out_cursor_visible;

  text_console_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_char_code(in_char_code),
    .in_target_col(in_target_col), .in_target_row(in_target_row),
    .in_prev_col(in_prev_col), .in_prev_row(in_prev_row),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row), .out_cell_char(out_cell_char),
    .out_cell_color(out_cell_color), .out_click_on(out_click_on),
    .out_cursor_visible(out_cursor_visible)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // console state mirror
  logic [7:0] scr_ch [CELLS];
  logic [7:0] scr_co [CELLS];
  int cur_c, cur_r, drw_c, drw_r;
  logic [7:0] sav_ch, sav_co;
  bit drawn, enabled, phase, click, metro;
  int blink_cnt, click_cnt;

  console_req_t pending_reqs[$];
  console_status_t status_q[$];
  int errors = 0;
  int n_results = 0;
  int n_reads = 0;
  int n_clicks = 0;

  function automatic void write_cell(int c, int r, logic [7:0] ch, logic [7:0] co);
    int i;
    i = r * COLUMNS + c;
    if (i < CELLS) begin
      scr_ch[i] = ch;
      scr_co[i] = co;
    end
  endfunction

  function automatic void draw_cursor_block();
    logic [7:0] fg, bg, co;
    fg = sav_co & COLOR_HI;
    bg = sav_co & COLOR_LO;
    co = (phase == 0) ? (fg | (fg >> 4)) : ((bg << 4) | bg);
    write_cell(drw_c, drw_r, BLANK_CHAR, co);
    drawn = 1;
  endfunction

  function automatic void hide_cursor();
    if (drawn) begin
      write_cell(drw_c, drw_r, sav_ch, sav_co);
      drawn = 0;
    end
  endfunction

  function automatic void redraw_cursor();
    int i;
    if (!enabled) return;
    phase = 0;
    blink_cnt = BLINK_FRAMES;
    i = cur_r * COLUMNS + cur_c;
    sav_ch = scr_ch[i];
    sav_co = scr_co[i];
    drw_c = cur_c;
    drw_r = cur_r;
    draw_cursor_block();
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) begin
      scr_ch[i] = BLANK_CHAR;
      scr_co[i] = PLAIN_ATTR;
    end
  endfunction

  function automatic void line_feed();
    cur_c = 0;
    if (cur_r >= ROWS - 1) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        scr_ch[i] = scr_ch[i + COLUMNS];
        scr_co[i] = scr_co[i + COLUMNS];
      end
      for (int c = 0; c < COLUMNS; c++) write_cell(c, ROWS - 1, BLANK_CHAR, PLAIN_ATTR);
    end else begin
      cur_r++;
    end
  endfunction

  function automatic void clear_console();
    hide_cursor();
    blank_screen();
    cur_c = 0;
    cur_r = 0;
    redraw_cursor();
  endfunction

  function automatic void move_cursor(int c, int r);
    hide_cursor();
    cur_c = c >= COLUMNS ? COLUMNS - 1 : c;
    cur_r = r >= ROWS ? ROWS - 1 : r;
    redraw_cursor();
  endfunction

  function automatic bit is_eol(logic [7:0] ch);
    return ch == CH_EOL || ch == CH_ESC || ch == CH_LF || ch == CH_CR;
  endfunction

  function automatic void console_reset();
    blank_screen();
    cur_c = 0; cur_r = 0; drw_c = 0; drw_r = 0;
    sav_ch = BLANK_CHAR; sav_co = PLAIN_ATTR;
    drawn = 0; enabled = 0; phase = 0; click = 0; metro = 0;
    blink_cnt = BLINK_FRAMES; click_cnt = CLICK_FRAMES;
  endfunction

  function automatic console_status_t console_step(console_req_t q);
    console_status_t s;
    logic [7:0] ch;
    int i;
    s = '0;
    ch = q.ch;
    case (req_t'(q.req))
      REQ_PUT: begin
        hide_cursor();
        if (is_eol(ch)) line_feed();
        else begin
          ch = ch & CH_MASK;
          if (ch == CH_BS || ch == CH_DEL) begin
            if (cur_c != 0) begin
              cur_c--;
              write_cell(cur_c, cur_r, BLANK_CHAR, PLAIN_ATTR);
            end
          end else if (ch >= BLANK_CHAR) begin
            write_cell(cur_c, cur_r, ch, PLAIN_ATTR);
            cur_c++;
            if (cur_c >= COLUMNS) line_feed();
          end
        end
        redraw_cursor();
      end
      REQ_HOOK: begin
        if (ch == CH_CLR) clear_console();
        else if (!is_eol(ch)) begin
          ch = ch & CH_MASK;
          if (q.pcol < COLUMNS && q.prow < ROWS && ch >= BLANK_CHAR) begin
            hide_cursor();
            write_cell(q.pcol, q.prow, ch, PLAIN_ATTR);
          end
        end
        move_cursor(q.tcol, q.trow);
      end
      REQ_CLEAR: clear_console();
      REQ_SET: move_cursor(q.tcol, q.trow);
      REQ_ENABLE: begin
        hide_cursor();
        enabled = 1;
        redraw_cursor();
      end
      REQ_TICK: begin
        click = 0;
        if (!metro) click_cnt = CLICK_FRAMES;
        else begin
          click_cnt--;
          if (click_cnt == 0) begin
            click_cnt = CLICK_FRAMES;
            click = 1;
          end
        end
        if (blink_cnt != 0) blink_cnt--;
        else begin
          blink_cnt = BLINK_FRAMES;
          if (drawn) begin
            phase ^= 1;
            draw_cursor_block();
          end
        end
      end
      REQ_READ: begin
        i = (q.trow >= ROWS ? ROWS - 1 : q.trow) * COLUMNS
          + (q.tcol >= COLUMNS ? COLUMNS - 1 : q.tcol);
        s.cch = scr_ch[i];
        s.ccolor = scr_co[i];
      end
      default: ;
    endcase
    s.col = 7'(cur_c);
    s.row = 5'(cur_r);
    s.click = click;
    s.vis = drawn;
    return s;
  endfunction

  // driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  bit hold = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        status_q.push_back(console_step(pending_reqs.pop_front()));
      end
      if (start && busy) begin
      end else if (!hold && gap_left == 0 && pending_reqs.size() != 0) begin
        start <= 1;
        in_req_type <= pending_reqs[0].req;
        in_char_code <= pending_reqs[0].ch;
        in_target_col <= pending_reqs[0].tcol;
        in_target_row <= pending_reqs[0].trow;
        in_prev_col <= pending_reqs[0].pcol;
        in_prev_row <= pending_reqs[0].prow;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    console_status_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (status_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = status_q.pop_front();
        if (e.cch != 0 || e.ccolor != 0) n_reads++;
        if (e.click) n_clicks++;
        if (out_cursor_col !== e.col) begin
          $error("cursor_col exp %0d got %0d", e.col, out_cursor_col); errors++;
        end
        if (out_cursor_row !== e.row) begin
          $error("cursor_row exp %0d got %0d", e.row, out_cursor_row); errors++;
        end
        if (out_cell_char !== e.cch) begin
          $error("cell_char exp %h got %h", e.cch, out_cell_char); errors++;
        end
        if (out_cell_color !== e.ccolor) begin
          $error("cell_color exp %h got %h", e.ccolor, out_cell_color); errors++;
        end
        if (out_click_on !== e.click) begin
          $error("click_on exp %0d got %0d", e.click, out_click_on); errors++;
        end
        if (out_cursor_visible !== e.vis) begin
          $error("cursor_visible exp %0d got %0d", e.vis, out_cursor_visible); errors++;
        end
      end
    end
  end

  function automatic console_req_t mk(logic [2:0] r, logic [7:0] ch, logic [7:0] tc,
                                     logic [7:0] tr, logic [7:0] pc, logic [7:0] pr);
    console_req_t q;
    q.req = r; q.ch = ch; q.tcol = tc; q.trow = tr; q.pcol = pc; q.prow = pr;
    return q;
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0: return CH_LF;
      1: return CH_EOL;
      2: return CH_BS;
      3: return CH_DEL;
      4: return 8'($urandom_range(0, 31));
      5: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(32, 125));
    endcase
  endfunction

  function automatic logic [7:0] rand_pos(int lim);
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, lim));
  endfunction

  function automatic console_req_t rand_req();
    int k;
    logic [2:0] r;
    k = $urandom_range(0, 99);
    if (k < 45) r = REQ_PUT;
    else if (k < 55) r = REQ_HOOK;
    else if (k < 57) r = REQ_CLEAR;
    else if (k < 64) r = REQ_SET;
    else if (k < 67) r = REQ_ENABLE;
    else if (k < 84) r = REQ_TICK;
    else if (k < 98) r = REQ_READ;
    else r = REQ_NONE;
    return mk(r, ($urandom_range(0, 15) == 0) ? CH_CLR : rand_char(),
              rand_pos(COLUMNS), rand_pos(ROWS), rand_pos(COLUMNS), rand_pos(ROWS));
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || status_q.size() != 0 || start) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_metronome(bit v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    metro = v;
  endtask

  initial begin
    console_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    // directed part
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_ENABLE, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_ENABLE, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, 8'h41, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, 8'hC2, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, 8'hFF, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, CH_BS, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, 8'h05, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, CH_ESC, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, CH_DEL, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SET, 0, 255, 255, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, 8'h5A, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PUT, CH_CR, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_HOOK, 8'h51, 3, 4, 79, 24));
    pending_reqs.push_back(mk(REQ_HOOK, 8'h52, 10, 10, 80, 0));
    pending_reqs.push_back(mk(REQ_HOOK, CH_LF, 0, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_READ, 0, 79, 24, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 255, 255, 0, 0));
    pending_reqs.push_back(mk(REQ_NONE, 8'hFF, 255, 255, 255, 255));
    for (int i = 0; i < 22; i++) pending_reqs.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_HOOK, CH_CLR, 5, 5, 0, 0));
    pending_reqs.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0));
    wait_drained();
    write_metronome(1);
    // random phases: bulk text plus mixed requests, metronome toggled between
    for (int ph = 0; ph < 4; ph++) begin
      hold = (ph == 2);
      for (int i = 0; i < 230; i++) pending_reqs.push_back(rand_req());
      if (ph == 2) begin
        repeat (30) @(posedge clk);
        hold = 0;
      end
      wait_drained();
      write_metronome(ph[0]);
    end
    $display("%0d results checked, %0d nonzero cell reads, %0d clicks, metronome on and off",
             n_results, n_reads, n_clicks);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #500ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

[sim.f]
hdl/tce_pkg.sv
hdl/tce_ram.sv
hdl/tce_front.sv
hdl/tce_back.sv
hdl/text_console_engine.sv
bench/tb_top.sv
